FILE: design/tcpq_pkg.sv
// Package for the two-class priority queue: sizes, codes and the structs
// shared by the top level, the controller and the slot store.
// No dependencies.
package tcpq_pkg;

    localparam int QDEPTH = 8;
    localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int ADDR_W = PTR_W + 1;
    localparam int DATA_W = 32;

    localparam logic signed [DATA_W-1:0] THRESH_RESET = 32'sd60;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BOTH_FULL = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] replacement_value;
    } req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] removed_value;
        logic                     served_class;
    } rsp_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

FILE: design/tcpq_store.sv
// Slot store for both class queues: one write port, one registered read port.
// The class bit is the top address bit. Depends on tcpq_pkg.
module tcpq_store (
    input  logic                      clk,
    input  tcpq_pkg::mem_req_t        mem_req,
    output logic [tcpq_pkg::DATA_W-1:0] rd_data
);
    import tcpq_pkg::*;

    logic [DATA_W-1:0] mem_reg [0:2*QDEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem_reg[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem_reg[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/tcpq_ctrl.sv
// Sequencer for the two-class priority queue: request capture, queue
// pointers and the shared compare used by the modify walk.
// Depends on tcpq_pkg; drives tcpq_store.
module tcpq_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  tcpq_pkg::req_t                   req,
    input  logic signed [tcpq_pkg::DATA_W-1:0] threshold,
    input  logic                             rsp_free,
    output logic                             rsp_load,
    output tcpq_pkg::rsp_t                   rsp_data,
    output tcpq_pkg::mem_req_t               mem_req,
    input  logic [tcpq_pkg::DATA_W-1:0]      rd_data
);
    import tcpq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_POP  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QDEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);

    state_t state_reg, state_next;

    logic [1:0]        op_reg,   op_next;
    logic [DATA_W-1:0] item_reg, item_next;
    logic [DATA_W-1:0] repl_reg, repl_next;
    logic              high_reg, high_next;
    logic [PTR_W-1:0]  scan_reg, scan_next;
    rsp_t              res_reg,  res_next;

    logic [PTR_W-1:0]  lo_head_reg, lo_head_next, lo_tail_reg, lo_tail_next;
    logic [PTR_W-1:0]  hi_head_reg, hi_head_next, hi_tail_reg, hi_tail_next;
    logic              lo_occ_reg, lo_occ_next, hi_occ_reg, hi_occ_next;

    logic              lo_full, hi_full, t_occ, t_full, hit;
    logic [PTR_W-1:0]  t_head, t_tail, push_ptr;

    assign lo_full  = lo_occ_reg && (lo_tail_reg == LAST_SLOT);
    assign hi_full  = hi_occ_reg && (hi_tail_reg == LAST_SLOT);
    assign t_occ    = high_reg ? hi_occ_reg  : lo_occ_reg;
    assign t_full   = high_reg ? hi_full     : lo_full;
    assign t_head   = high_reg ? hi_head_reg : lo_head_reg;
    assign t_tail   = high_reg ? hi_tail_reg : lo_tail_reg;
    assign push_ptr = t_occ ? (t_tail + PTR_ONE) : '0;
    assign hit      = (rd_data == item_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_load  = (state_reg == S_DONE) && rsp_free;
    assign rsp_data  = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        item_next    = item_reg;
        repl_next    = repl_reg;
        high_next    = high_reg;
        scan_next    = scan_reg;
        res_next     = res_reg;
        lo_head_next = lo_head_reg;
        lo_tail_next = lo_tail_reg;
        lo_occ_next  = lo_occ_reg;
        hi_head_next = hi_head_reg;
        hi_tail_next = hi_tail_reg;
        hi_occ_next  = hi_occ_reg;
        mem_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    item_next  = req.item_value;
                    repl_next  = req.replacement_value;
                    high_next  = (req.item_value > threshold);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_DONE;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        res_next.served_class = high_reg;
                        if (lo_full && hi_full)
                        begin
                            res_next.status = ST_BOTH_FULL;
                        end
                        else if (t_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = {high_reg, push_ptr};
                            mem_req.wr_data = item_reg;
                            if (high_reg)
                            begin
                                hi_tail_next = push_ptr;
                                hi_occ_next  = 1'b1;
                                if (!hi_occ_reg)
                                begin
                                    hi_head_next = '0;
                                end
                            end
                            else
                            begin
                                lo_tail_next = push_ptr;
                                lo_occ_next  = 1'b1;
                                if (!lo_occ_reg)
                                begin
                                    lo_head_next = '0;
                                end
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hi_occ_reg)
                        begin
                            mem_req.rd_en         = 1'b1;
                            mem_req.rd_addr       = {1'b1, hi_head_reg};
                            res_next.served_class = 1'b1;
                            state_next            = S_POP;
                        end
                        else if (lo_occ_reg)
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = {1'b0, lo_head_reg};
                            state_next      = S_POP;
                        end
                        else
                        begin
                            res_next.status = ST_EMPTY;
                        end
                    end
                    OP_MODIFY:
                    begin
                        res_next.served_class = high_reg;
                        if (!t_occ)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = {high_reg, t_head};
                            scan_next       = t_head;
                            state_next      = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end

            S_POP:
            begin
                res_next.removed_value = rd_data;
                state_next             = S_DONE;
                if (res_reg.served_class)
                begin
                    if (hi_head_reg == hi_tail_reg)
                    begin
                        hi_head_next = '0;
                        hi_tail_next = '0;
                        hi_occ_next  = 1'b0;
                    end
                    else
                    begin
                        hi_head_next = hi_head_reg + PTR_ONE;
                    end
                end
                else
                begin
                    if (lo_head_reg == lo_tail_reg)
                    begin
                        lo_head_next = '0;
                        lo_tail_next = '0;
                        lo_occ_next  = 1'b0;
                    end
                    else
                    begin
                        lo_head_next = lo_head_reg + PTR_ONE;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = {high_reg, scan_reg};
                    mem_req.wr_data = repl_reg;
                    res_next.status = ST_OK;
                    state_next      = S_DONE;
                end
                else if (scan_reg == t_tail)
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = {high_reg, scan_reg + PTR_ONE};
                    scan_next       = scan_reg + PTR_ONE;
                end
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lo_head_reg <= '0;
            lo_tail_reg <= '0;
            lo_occ_reg  <= 1'b0;
            hi_head_reg <= '0;
            hi_tail_reg <= '0;
            hi_occ_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lo_head_reg <= lo_head_next;
            lo_tail_reg <= lo_tail_next;
            lo_occ_reg  <= lo_occ_next;
            hi_head_reg <= hi_head_next;
            hi_tail_reg <= hi_tail_next;
            hi_occ_reg  <= hi_occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        item_reg <= item_next;
        repl_reg <= repl_next;
        high_reg <= high_next;
        scan_reg <= scan_next;
        res_reg  <= res_next;
    end

endmodule

FILE: design/two_class_priority_queue.sv
// Two-class strict-priority queue: top level with threshold register and
// output register. Depends on tcpq_pkg, tcpq_ctrl and tcpq_store.
// Usage:
//   Requests enter on req_valid/req_ready with req (opcode, item_value,
//   replacement_value); one response per request leaves on
//   rsp_valid/rsp_ready with rsp (status, removed_value, served_class).
//   cfg_wr_en/cfg_wr_data write the threshold (thresh_reg); write it only
//   while no request is in flight.
// Sequencing:
//   Insert, unused opcodes and a request that finds its queue empty go
//   straight to their result; a remove first reads the head slot, and a
//   modify walks the queue from the head, comparing each entry, until a
//   match or the tail. The next request is accepted only once the last
//   response is loaded into the output register; the single read port of
//   the slot store and the one shared equality compare set the pace.
// Reset:
//   rst_n clears both queues to empty and sets the threshold to 60.
// Stall:
//   While rsp_ready is low the response holds in the output register; one
//   more request can be worked up to its result and then waits.
module two_class_priority_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  tcpq_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output tcpq_pkg::rsp_t                   rsp,
    input  logic                             cfg_wr_en,
    input  logic signed [tcpq_pkg::DATA_W-1:0] cfg_wr_data
);
    import tcpq_pkg::*;

    logic signed [DATA_W-1:0] thresh_reg;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_data;
    logic                     rsp_load;
    logic                     rsp_free;
    mem_req_t                 mem_req;
    logic [DATA_W-1:0]        rd_data;

    assign rsp_free = !rsp_valid_reg || rsp_ready;

    tcpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .threshold (thresh_reg),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .rsp_data  (rsp_data),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    tcpq_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
